[design/ufd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ufd_pkg: shared types and constants of the UART frame deserializer
// Register indexes, parity codes, field widths and the result record.
// ----------------------------------------------------------------------------
package ufd_pkg;

  localparam int WORD_W    = 10;
  localparam int COUNT_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 4;
  localparam int NBITS_W   = 4;
  localparam int PMODE_W   = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_BITS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PARITY_MODE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_INVERTED = 2'd2;

  // Parity codes. The remaining code behaves as no parity.
  localparam logic [PMODE_W-1:0] PAR_NONE = 2'd0;
  localparam logic [PMODE_W-1:0] PAR_EVEN = 2'd1;
  localparam logic [PMODE_W-1:0] PAR_ODD  = 2'd2;

  localparam logic [NBITS_W-1:0] DATA_BITS_RESET = 4'd8;

  typedef struct packed {
    logic                frame_done;
    logic                word_valid;
    logic [WORD_W-1:0]   received_word;
    logic [COUNT_W-1:0]  parity_error_total;
  } result_t;

endpackage
`default_nettype wire

[design/ufd_out_skid.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ufd_out_skid: result register with skid stage
// Holds finished results; the input side takes one more while the output
// side stalls; order is preserved.
// ----------------------------------------------------------------------------
module ufd_out_skid
  import ufd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire result_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_data
);

  logic    main_valid;
  result_t main_data;
  logic    skid_valid;
  result_t skid_data;

  assign in_ready  = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !main_valid) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= in_valid;
      end
    end else if (in_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (out_ready || !main_valid) begin
      main_data <= skid_valid ? skid_data : in_data;
    end
    if (!skid_valid) begin
      skid_data <= in_data;
    end
  end

endmodule
`default_nettype wire

[design/uart_frame_deserializer.sv]
`timescale 1ns / 1ps
`default_nettype none
// Results are registered in the output stage; frame state updates in one pass.
// Throughput: one line sample per cycle while the skid entry is free (in_ready).
// A two-entry output stage (result register plus skid) lets a sample enter
// while one result waits to be taken.
// Reset: data_bits 8, no parity, normal polarity; frame state and the
// parity error counter clear to zero.
// ----------------------------------------------------------------------------
// uart_frame_deserializer: UART receive frame decoder with parity check
// Takes mid-bit line samples, assembles data words LSB first, checks parity
// and counts parity errors.
// ----------------------------------------------------------------------------
module uart_frame_deserializer
  import ufd_pkg::*;
#(
  parameter int MAX_DATA_BITS = 10
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 line_sample,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      frame_done,
  output logic                      word_valid,
  output logic [WORD_W-1:0]         received_word,
  output logic [COUNT_W-1:0]        parity_error_total
);

  localparam int POS_W = $clog2(MAX_DATA_BITS + 2);
  localparam int CMP_W = (POS_W > NBITS_W) ? POS_W : NBITS_W;
  localparam int SH_W  = (MAX_DATA_BITS > 1) ? $clog2(MAX_DATA_BITS) : 1;

  // Configuration registers.
  logic [NBITS_W-1:0] data_bits;
  logic [PMODE_W-1:0] parity_mode;
  logic               line_inverted;

  always_ff @(posedge clk) begin
    if (rst) begin
      data_bits     <= DATA_BITS_RESET;
      parity_mode   <= PAR_NONE;
      line_inverted <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_DATA_BITS:     data_bits     <= cfg_data[NBITS_W-1:0];
        CFG_PARITY_MODE:   parity_mode   <= cfg_data[PMODE_W-1:0];
        CFG_LINE_INVERTED: line_inverted <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Frame state.
  logic [POS_W-1:0]         bit_position;
  logic [POS_W-1:0]         bit_position_next;
  logic [MAX_DATA_BITS-1:0] data_shift;
  logic [MAX_DATA_BITS-1:0] data_shift_next;
  logic                     ones_parity;
  logic                     ones_parity_next;
  logic [COUNT_W-1:0]       parity_error_counter;
  logic [COUNT_W-1:0]       parity_error_counter_next;

  logic               accept;
  logic [CMP_W-1:0]   nbits_wide;
  logic [POS_W-1:0]   nbits;
  logic               parity_on;
  logic               bit_val;
  logic               sum;
  logic               done;
  logic               valid;
  logic [SH_W-1:0]    shift_idx;
  logic [POS_W-1:0]   pos_m1;
  logic [WORD_W-1:0]  word_full;
  result_t            result;
  logic               skid_ready;

  assign accept   = in_valid && in_ready;
  assign in_ready = skid_ready;

  always_comb begin
    if (data_bits == '0) begin
      nbits_wide = CMP_W'(1);
    end else if (CMP_W'(data_bits) > CMP_W'(MAX_DATA_BITS)) begin
      nbits_wide = CMP_W'(MAX_DATA_BITS);
    end else begin
      nbits_wide = CMP_W'(data_bits);
    end
  end
  assign nbits = nbits_wide[POS_W-1:0];

  assign parity_on = (parity_mode == PAR_EVEN) || (parity_mode == PAR_ODD);
  assign bit_val   = line_sample ^ line_inverted;
  assign sum       = ones_parity ^ bit_val;
  assign pos_m1    = bit_position - POS_W'(1);
  assign shift_idx = pos_m1[SH_W-1:0];

  always_comb begin
    bit_position_next = bit_position;
    data_shift_next   = data_shift;
    ones_parity_next  = ones_parity;
    done              = 1'b0;
    valid             = 1'b0;
    if (bit_position == '0) begin
      // Start bit: not examined.
      bit_position_next = POS_W'(1);
    end else if (bit_position <= nbits) begin
      data_shift_next[shift_idx] = data_shift[shift_idx] | bit_val;
      ones_parity_next           = sum;
      if (bit_position >= nbits && !parity_on) begin
        done  = 1'b1;
        valid = 1'b1;
      end else begin
        bit_position_next = bit_position + POS_W'(1);
      end
    end else begin
      // Parity sample, or a sample past the data bits after a
      // configuration change with parity off.
      done = 1'b1;
      if (!parity_on) begin
        valid = 1'b1;
      end else if (parity_mode == PAR_EVEN) begin
        valid = !sum;
      end else begin
        valid = sum;
      end
    end
    if (done) begin
      bit_position_next = '0;
      ones_parity_next  = 1'b0;
    end
  end

  assign parity_error_counter_next = (done && !valid) ?
      parity_error_counter + COUNT_W'(1) : parity_error_counter;

  generate
    if (MAX_DATA_BITS >= WORD_W) begin : g_word_trunc
      assign word_full = data_shift_next[WORD_W-1:0];
    end else begin : g_word_ext
      assign word_full = {{(WORD_W - MAX_DATA_BITS){1'b0}}, data_shift_next};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_position         <= '0;
      data_shift           <= '0;
      ones_parity          <= 1'b0;
      parity_error_counter <= '0;
    end else if (accept) begin
      bit_position         <= bit_position_next;
      data_shift           <= done ? '0 : data_shift_next;
      ones_parity          <= ones_parity_next;
      parity_error_counter <= parity_error_counter_next;
    end
  end

  always_comb begin
    result.frame_done         = done;
    result.word_valid         = valid;
    result.received_word      = (done && valid) ? word_full : '0;
    result.parity_error_total = parity_error_counter_next;
  end

  result_t out_data;

  ufd_out_skid u_out_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (skid_ready),
    .in_data   (result),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign frame_done         = out_data.frame_done;
  assign word_valid         = out_data.word_valid;
  assign received_word      = out_data.received_word;
  assign parity_error_total = out_data.parity_error_total;

  // A valid word is only reported on a completed frame.
  a_valid_needs_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && word_valid |-> frame_done)
    else $error("word_valid without frame_done");

  // Outside a good frame the word is zero.
  a_word_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !(frame_done && word_valid) |-> received_word == '0)
    else $error("received_word nonzero without a good frame");

  // The error counter moves only on a parity error transaction.
  a_count_stable: assert property (@(posedge clk) disable iff (rst)
    !(accept && done && !valid) |=> $stable(parity_error_counter))
    else $error("parity error counter changed without an error");

  // A completed frame returns to waiting for the start bit.
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    accept && done |=> bit_position == '0)
    else $error("frame state not cleared after frame end");

  // The position never passes the last data bit plus parity.
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    bit_position <= POS_W'(MAX_DATA_BITS + 1))
    else $error("bit position out of range");

endmodule
`default_nettype wire

[tb/uart_frame_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_frame_checker: result predictor and comparator for the frame decoder
// Watches the register port and both channels, decodes every accepted line
// sample on its own copy of the frame state, and compares each result
// transaction with the oldest expected result.
// ----------------------------------------------------------------------------
module uart_frame_checker
  import ufd_pkg::*;
#(
  parameter int MAX_DATA_BITS = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 line_sample,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 frame_done,
  input  logic                 word_valid,
  input  logic [WORD_W-1:0]    received_word,
  input  logic [COUNT_W-1:0]   parity_error_total,
  output int unsigned          mismatch_count,
  output int unsigned          results_due
);

  // Register copies.
  logic [NBITS_W-1:0] nbits_reg;
  logic [PMODE_W-1:0] pmode_reg;
  logic               invert_reg;

  // Frame state copies.
  logic [NBITS_W-1:0] bit_pos;
  logic [WORD_W-1:0]  word_acc;
  logic               ones_par;
  logic [COUNT_W-1:0] err_count;

  result_t awaited_results[$];

  function automatic result_t decode_sample(input logic sample);
    result_t            res;
    logic [NBITS_W-1:0] nbits;
    logic               par_on;
    logic               data_bit;
    logic               good;
    res = '0;
    good = 1'b0;
    nbits = nbits_reg;
    if (nbits == '0) nbits = NBITS_W'(1);
    if (nbits > MAX_DATA_BITS) nbits = NBITS_W'(MAX_DATA_BITS);
    par_on = (pmode_reg == PAR_EVEN) || (pmode_reg == PAR_ODD);
    data_bit = sample ^ invert_reg;

    if (bit_pos == '0) begin
      // Start bit: only moves the frame along.
      bit_pos = NBITS_W'(1);
    end else if (bit_pos <= nbits) begin
      word_acc = word_acc | (WORD_W'(data_bit) << (bit_pos - NBITS_W'(1)));
      ones_par = ones_par ^ data_bit;
      if (bit_pos >= nbits && !par_on) begin
        res.frame_done = 1'b1;
        good = 1'b1;
      end else begin
        bit_pos = bit_pos + NBITS_W'(1);
      end
    end else begin
      // Past the data bits: parity sample, or an ignored sample that still
      // closes the frame when parity is off.
      res.frame_done = 1'b1;
      if (!par_on) good = 1'b1;
      else if (pmode_reg == PAR_EVEN) good = !(ones_par ^ data_bit);
      else good = ones_par ^ data_bit;
    end

    if (res.frame_done) begin
      if (good) res.received_word = word_acc;
      else err_count = err_count + COUNT_W'(1);
      bit_pos = '0;
      word_acc = '0;
      ones_par = 1'b0;
    end
    res.word_valid = good;
    res.parity_error_total = err_count;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      nbits_reg = DATA_BITS_RESET;
      pmode_reg = PAR_NONE;
      invert_reg = 1'b0;
      bit_pos = '0;
      word_acc = '0;
      ones_par = 1'b0;
      err_count = '0;
      mismatch_count = 0;
      awaited_results.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_DATA_BITS:     nbits_reg = cfg_data[NBITS_W-1:0];
          CFG_PARITY_MODE:   pmode_reg = cfg_data[PMODE_W-1:0];
          CFG_LINE_INVERTED: invert_reg = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $error("result transaction with no expected result waiting");
          mismatch_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("frame_done", 32'(want.frame_done), 32'(frame_done));
          check_field("word_valid", 32'(want.word_valid), 32'(word_valid));
          check_field("received_word", 32'(want.received_word), 32'(received_word));
          check_field("parity_error_total", want.parity_error_total,
                      parity_error_total);
        end
      end
      if (in_valid && in_ready) awaited_results.push_back(decode_sample(line_sample));
    end
    results_due = awaited_results.size();
  end

endmodule

[tb/tb_uart_frame_deserializer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uart_frame_deserializer: testbench top for the UART frame decoder
// Sends well-formed frames with random data and occasional parity faults
// across many register settings, including writes in the middle of a frame,
// with random idle bursts on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_uart_frame_deserializer;
  import ufd_pkg::*;

  localparam int MAX_DATA_BITS = 10;
  localparam int LONG_HOLD = 300;
  localparam logic [PMODE_W-1:0] PAR_UNUSED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_DATA_BITS;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 line_sample = 1'b0;
  logic                 out_ready = 1'b0;
  logic                 in_ready;
  logic                 out_valid;
  logic                 frame_done;
  logic                 word_valid;
  logic [WORD_W-1:0]    received_word;
  logic [COUNT_W-1:0]   parity_error_total;
  int unsigned          mismatch_count;
  int unsigned          results_due;

  // Stimulus-side view of the registers, used only to shape frames.
  logic [NBITS_W-1:0] set_bits = DATA_BITS_RESET;
  logic [PMODE_W-1:0] set_parity = PAR_NONE;
  logic               set_invert = 1'b0;

  int  samples_sent = 0;
  int  open_pos = 0;
  bit  steady_flow = 1'b0;
  bit  backlog_req = 1'b0;
  bit  backlog_served = 1'b0;
  int  rx_stall_left = 0;

  uart_frame_deserializer #(.MAX_DATA_BITS(MAX_DATA_BITS)) uut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .line_sample(line_sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .frame_done(frame_done), .word_valid(word_valid),
    .received_word(received_word), .parity_error_total(parity_error_total)
  );

  uart_frame_checker #(.MAX_DATA_BITS(MAX_DATA_BITS)) checker_i (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .line_sample(line_sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .frame_done(frame_done), .word_valid(word_valid),
    .received_word(received_word), .parity_error_total(parity_error_total),
    .mismatch_count(mismatch_count), .results_due(results_due)
  );

  always #2 clk = ~clk;

  // Result side: random stall bursts, plus one long stall on request.
  always @(negedge clk) begin
    if (rx_stall_left > 0) begin
      rx_stall_left--;
      out_ready <= 1'b0;
    end else if (backlog_req && !backlog_served) begin
      backlog_served = 1'b1;
      rx_stall_left = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else if (!steady_flow && $urandom_range(0, 7) == 0) begin
      rx_stall_left = $urandom_range(1, 17) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic int frame_bits();
    if (set_bits == 0) return 1;
    if (set_bits > MAX_DATA_BITS) return MAX_DATA_BITS;
    return int'(set_bits);
  endfunction

  function automatic bit parity_used();
    return (set_parity == PAR_EVEN) || (set_parity == PAR_ODD);
  endfunction

  task automatic push_sample(input logic level);
    @(negedge clk);
    if (!steady_flow && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid <= 1'b1;
    line_sample <= level;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic apply_setting(input logic [NBITS_W-1:0] bits,
                               input logic [PMODE_W-1:0] parity, input logic invert);
    write_reg(CFG_DATA_BITS, bits);
    write_reg(CFG_PARITY_MODE, CFG_W'(parity));
    write_reg(CFG_LINE_INVERTED, CFG_W'(invert));
    set_bits = bits;
    set_parity = parity;
    set_invert = invert;
  endtask

  task automatic send_frame(input logic [WORD_W-1:0] data, input bit corrupt);
    int                n;
    logic [WORD_W-1:0] mask;
    logic              par;
    n = frame_bits();
    mask = WORD_W'((1 << n) - 1);
    par = ^(data & mask);
    // The start bit level is never examined, so it is random.
    push_sample(1'($urandom_range(0, 1)));
    for (int i = 0; i < n; i++) push_sample(data[i] ^ set_invert);
    if (parity_used()) begin
      if (set_parity == PAR_ODD) par = ~par;
      push_sample(par ^ set_invert ^ corrupt);
    end
  endtask

  // A frame left open across a register write finishes under the new
  // setting; this sends exactly the samples that close it.
  task automatic close_open_frame();
    int tail;
    if (open_pos == 0) return;
    if (open_pos > frame_bits()) tail = 1;
    else tail = frame_bits() - open_pos + 1 + (parity_used() ? 1 : 0);
    repeat (tail) push_sample(1'($urandom_range(0, 1)));
    open_pos = 0;
  endtask

  initial begin
    logic [NBITS_W-1:0] bits;
    logic [PMODE_W-1:0] parity;
    int                 phase_end;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset setting, a full-width all-ones frame with a parity fault, and the
    // clamped zero width with the unused parity code on an inverted line.
    send_frame(10'h0A5, 1'b0);
    apply_setting(4'd10, PAR_EVEN, 1'b0);
    send_frame(10'h3FF, 1'b1);
    apply_setting(4'd0, PAR_UNUSED, 1'b1);
    send_frame(10'h001, 1'b0);

    for (int phase = 0; phase < 24; phase++) begin
      case (phase % 6)
        0: bits = 4'd0;
        1: bits = 4'd15;
        2: bits = 4'd10;
        3: bits = 4'd1;
        default: bits = NBITS_W'($urandom_range(0, 15));
      endcase
      case (phase % 4)
        0: parity = PAR_NONE;
        1: parity = PAR_EVEN;
        2: parity = PAR_ODD;
        default: parity = PAR_UNUSED;
      endcase
      apply_setting(bits, parity, phase % 3 == 0);
      close_open_frame();
      if (phase == 8) backlog_req = 1'b1;
      if (phase >= 21) steady_flow = 1'b1;
      phase_end = samples_sent + 44;
      while (samples_sent < phase_end)
        send_frame(WORD_W'($urandom), $urandom_range(0, 3) == 0);
      // Leave some phases with a frame still open across the next writes.
      if ($urandom_range(0, 1) == 1) begin
        open_pos = $urandom_range(1, frame_bits());
        repeat (open_pos) push_sample(1'($urandom_range(0, 1)));
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    repeat (5000) begin
      if (results_due == 0) break;
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
    if (mismatch_count == 0 && results_due == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
